FILE: rtl/dcpd_pkg.sv
// Shared constants, register codes and control types for the dual channel PID drive.
`default_nettype none

package dcpd_pkg;

  localparam int POSITION_BITS_DEF      = 32;
  localparam int GAIN_FRACTION_BITS_DEF = 20;
  localparam int SUM_BITS_DEF           = 40;

  localparam int GAIN_BITS      = 24;
  localparam int LIMIT_BITS     = 16;
  localparam int DRIVE_BITS     = 8;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [GAIN_BITS-1:0]  GAIN_P_RESET       = 24'd57672;
  localparam logic [GAIN_BITS-1:0]  GAIN_I_RESET       = 24'd524;
  localparam logic [GAIN_BITS-1:0]  GAIN_D_RESET       = 24'd524288;
  localparam logic [LIMIT_BITS-1:0] SETTLE_LIMIT_RESET = 16'd20;

  localparam logic [DRIVE_BITS-2:0] DRIVE_MAG_MAX = 7'd127;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_SETTLE_LIMIT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
  } dcpd_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/dual_channel_pid_drive.sv
// Top level: two PID lanes, configuration registers, stage control and merged output word.
//
// Usage:
//   in_tdata carries target_left, target_right, position_left, position_right,
//   POSITION_BITS each, lowest field first. out_tdata returns drive_left,
//   drive_right (8 bit signed, clamped to +/-127), settled_left, settled_right.
//   Each input word yields exactly one output word, in order.
//   From acceptance to out_tvalid a word passes error and integral
//   update, gain multiply, three-term add, then clamp into the output register.
//   Throughput is one word per cycle while out_tready is high; the integral
//   and last-error registers update in the accept cycle, so consecutive
//   words chain with no gap. Each stage holds its word while the next is
//   full; in_tready stays high while any stage is empty, so up to four words
//   sit in the pipe when the receiver stalls.
//   Reset (rst_n low, synchronous) clears integrals, last errors, the pipe and
//   loads default gains. Write gains through cfg_we/cfg_index/cfg_wdata while
//   idle; unknown indices are ignored.
`default_nettype none

module dual_channel_pid_drive #(
  parameter int POSITION_BITS      = dcpd_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = dcpd_pkg::GAIN_FRACTION_BITS_DEF,
  parameter int SUM_BITS           = dcpd_pkg::SUM_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // target_left, target_right, position_left, position_right
  input  wire logic [((4*POSITION_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // drive_left[7:0], drive_right[15:8], settled_left[16], settled_right[17]
  output logic [23:0]                                out_tdata,
  input  wire logic                                  cfg_we,
  input  wire logic [dcpd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [dcpd_pkg::GAIN_BITS-1:0]        cfg_wdata
);
  import dcpd_pkg::*;

  localparam int PB = POSITION_BITS;

  logic [GAIN_BITS-1:0]  gain_p_r;
  logic [GAIN_BITS-1:0]  gain_i_r;
  logic [GAIN_BITS-1:0]  gain_d_r;
  logic [LIMIT_BITS-1:0] settle_limit_r;

  logic v1_r, v2_r, v3_r, vout_r;
  logic v1_nxt, v2_nxt, v3_nxt, vout_nxt;
  logic rdy_out, rdy3, rdy2, rdy1;
  logic en_out;
  dcpd_ctl_t ctl;

  logic signed [DRIVE_BITS-1:0] drive_left, drive_right;
  logic                         settled_left, settled_right;
  logic [23:0]                  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r       <= GAIN_P_RESET;
      gain_i_r       <= GAIN_I_RESET;
      gain_d_r       <= GAIN_D_RESET;
      settle_limit_r <= SETTLE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:       gain_p_r       <= cfg_wdata;
        REG_GAIN_I:       gain_i_r       <= cfg_wdata;
        REG_GAIN_D:       gain_d_r       <= cfg_wdata;
        REG_SETTLE_LIMIT: settle_limit_r <= cfg_wdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy_out   = !vout_r || out_tready;
    rdy3      = !v3_r || rdy_out;
    rdy2      = !v2_r || rdy3;
    rdy1      = !v1_r || rdy2;
    in_tready = rdy1;
    ctl.load  = in_tvalid && rdy1;
    ctl.mul   = v1_r && rdy2;
    ctl.add   = v2_r && rdy3;
    en_out    = v3_r && rdy_out;
    v1_nxt    = ctl.load || (v1_r && !ctl.mul);
    v2_nxt    = ctl.mul  || (v2_r && !ctl.add);
    v3_nxt    = ctl.add  || (v3_r && !en_out);
    vout_nxt  = en_out   || (vout_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      v3_r   <= v3_nxt;
      vout_r <= vout_nxt;
    end
  end

  dcpd_lane #(
    .POSITION_BITS      (POSITION_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .SUM_BITS           (SUM_BITS)
  ) u_lane_left (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .target       ($signed(in_tdata[PB-1:0])),
    .position     ($signed(in_tdata[3*PB-1:2*PB])),
    .gain_p       (gain_p_r),
    .gain_i       (gain_i_r),
    .gain_d       (gain_d_r),
    .settle_limit (settle_limit_r),
    .drive        (drive_left),
    .settled      (settled_left)
  );

  dcpd_lane #(
    .POSITION_BITS      (POSITION_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .SUM_BITS           (SUM_BITS)
  ) u_lane_right (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .target       ($signed(in_tdata[2*PB-1:PB])),
    .position     ($signed(in_tdata[4*PB-1:3*PB])),
    .gain_p       (gain_p_r),
    .gain_i       (gain_i_r),
    .gain_d       (gain_d_r),
    .settle_limit (settle_limit_r),
    .drive        (drive_right),
    .settled      (settled_right)
  );

  // merge both lanes into one word
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= {6'd0, settled_right, settled_left, drive_right, drive_left};
    end
  end

  assign out_tvalid = vout_r;
  assign out_tdata  = out_data_r;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vout_r |-> in_tready)
    else $error("input stalled with empty output stage");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> v1_r)
    else $error("accepted word lost from first stage");

  a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy_out) |=> v3_r)
    else $error("stage 3 dropped a word under stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

FILE: rtl/dcpd_lane.sv
// One PID channel: error, integral and derivative, weighted sum, truncation and clamp.
`default_nettype none

module dcpd_lane #(
  parameter int POSITION_BITS      = dcpd_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = dcpd_pkg::GAIN_FRACTION_BITS_DEF,
  parameter int SUM_BITS           = dcpd_pkg::SUM_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire dcpd_pkg::dcpd_ctl_t                     ctl,
  input  wire logic signed [POSITION_BITS-1:0]         target,
  input  wire logic signed [POSITION_BITS-1:0]         position,
  input  wire logic        [dcpd_pkg::GAIN_BITS-1:0]   gain_p,
  input  wire logic        [dcpd_pkg::GAIN_BITS-1:0]   gain_i,
  input  wire logic        [dcpd_pkg::GAIN_BITS-1:0]   gain_d,
  input  wire logic        [dcpd_pkg::LIMIT_BITS-1:0]  settle_limit,
  output logic signed      [dcpd_pkg::DRIVE_BITS-1:0]  drive,
  output logic                                         settled
);
  import dcpd_pkg::*;

  localparam int EW  = POSITION_BITS + 1;
  localparam int DW  = POSITION_BITS + 2;
  localparam int XW  = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;
  localparam int CW  = (EW > LIMIT_BITS) ? EW : LIMIT_BITS;
  localparam int GW  = GAIN_BITS + 1;
  localparam int PW  = GW + EW;
  localparam int IW  = GW + SUM_BITS;
  localparam int QW  = GW + DW;
  localparam int MW  = (IW > QW) ? IW : QW;
  localparam int AW  = MW + 2;

  localparam logic signed [XW-1:0] SMAX = {{(XW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN = ~SMAX;

  logic signed [SUM_BITS-1:0] sum_r;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic signed [EW-1:0]       prev_r;
  logic signed [EW-1:0]       err;
  logic signed [DW-1:0]       diff;
  logic signed [XW-1:0]       sum_wide;
  logic        [EW-1:0]       err_abs;
  logic                       settled_nxt;

  logic signed [EW-1:0]       e1_r;
  logic signed [SUM_BITS-1:0] s1_r;
  logic signed [DW-1:0]       d1_r;
  logic                       settled1_r;

  logic signed [PW-1:0]       pp_r;
  logic signed [IW-1:0]       pi_r;
  logic signed [QW-1:0]       pd_r;
  logic                       settled2_r;

  logic signed [AW-1:0]       acc_r;
  logic                       settled3_r;

  logic        [AW-1:0]       mag;
  logic        [AW-1:0]       quo;
  logic                       big;
  logic        [DRIVE_BITS-2:0] mag7;

  always_comb begin
    err      = EW'(target) - EW'(position);
    diff     = DW'(err) - DW'(prev_r);
    sum_wide = XW'(sum_r) + XW'(err);
    if (sum_wide > SMAX) begin
      sum_nxt = SUM_BITS'(SMAX);
    end else if (sum_wide < SMIN) begin
      sum_nxt = SUM_BITS'(SMIN);
    end else begin
      sum_nxt = SUM_BITS'(sum_wide);
    end
    if (err == '0) begin
      sum_nxt = '0;
    end
    err_abs     = err[EW-1] ? EW'(-err) : EW'(err);
    settled_nxt = (CW'(err_abs) <= CW'(settle_limit));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      prev_r <= '0;
    end else if (ctl.load) begin
      sum_r  <= sum_nxt;
      prev_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      e1_r       <= err;
      s1_r       <= sum_nxt;
      d1_r       <= diff;
      settled1_r <= settled_nxt;
    end
    if (ctl.mul) begin
      pp_r       <= $signed({1'b0, gain_p}) * e1_r;
      pi_r       <= $signed({1'b0, gain_i}) * s1_r;
      pd_r       <= $signed({1'b0, gain_d}) * d1_r;
      settled2_r <= settled1_r;
    end
    if (ctl.add) begin
      acc_r      <= AW'(pp_r) + AW'(pi_r) + AW'(pd_r);
      settled3_r <= settled2_r;
    end
  end

  always_comb begin
    mag  = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
    quo  = mag >> GAIN_FRACTION_BITS;
    big  = |quo[AW-1:DRIVE_BITS-1];
    mag7 = big ? DRIVE_MAG_MAX : quo[DRIVE_BITS-2:0];
    drive = acc_r[AW-1] ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});
    settled = settled3_r;
  end

endmodule

`default_nettype wire

FILE: dv/tb_dual_channel_pid_drive.sv
// Self-checking stream testbench for the dual channel PID drive with a built-in lane predictor.
`default_nettype none

module tb_dual_channel_pid_drive;
  timeunit 1ns;
  timeprecision 1ps;

  import dcpd_pkg::*;

  localparam int POS_W   = POSITION_BITS_DEF;
  localparam int IN_W    = ((4*POS_W+7)/8)*8;
  localparam int HOLD_LEN = 300;
  localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< (SUM_BITS_DEF-1)) - 64'sd1;
  localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct {
    logic [7:0] drive_left;
    logic [7:0] drive_right;
    logic       settled_left;
    logic       settled_right;
  } drive_cmd_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_W-1:0]           in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [23:0]               out_tdata;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [GAIN_BITS-1:0]      cfg_wdata = '0;

  dual_channel_pid_drive DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  logic [IN_W-1:0]  tick_queue [$];
  drive_cmd_t       drive_expect_q [$];
  int unsigned      ticks_queued = 0;
  int unsigned      ticks_accepted = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_req_count = 0;
  int unsigned      hold_seen_count = 0;
  int unsigned      hold_left = 0;
  int               errors = 0;

  logic [GAIN_BITS-1:0]  gain_p_q = GAIN_P_RESET;
  logic [GAIN_BITS-1:0]  gain_i_q = GAIN_I_RESET;
  logic [GAIN_BITS-1:0]  gain_d_q = GAIN_D_RESET;
  logic [LIMIT_BITS-1:0] settle_limit_q = SETTLE_LIMIT_RESET;
  logic signed [63:0]    lane_sum [2] = '{64'sd0, 64'sd0};
  logic signed [63:0]    lane_prev [2] = '{64'sd0, 64'sd0};
  logic [POS_W-1:0]      walk_tgt [2] = '{'0, '0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void pid_lane(input int lane, input logic [POS_W-1:0] tgt,
                                   input logic [POS_W-1:0] pos,
                                   output logic [7:0] drive, output logic settled);
    logic signed [63:0]  err;
    logic signed [63:0]  integ;
    logic signed [63:0]  diff;
    logic signed [63:0]  err_mag;
    logic signed [127:0] acc;
    logic [127:0]        acc_mag;
    logic [127:0]        whole;
    logic [7:0]          mag8;
    err = $signed(tgt) - $signed(pos);
    integ = lane_sum[lane] + err;
    if (integ > SUM_MAX) integ = SUM_MAX;
    if (integ < SUM_MIN) integ = SUM_MIN;
    if (err == 0) integ = 0;
    diff = err - lane_prev[lane];
    lane_sum[lane] = integ;
    lane_prev[lane] = err;
    err_mag = (err < 0) ? -err : err;
    settled = (err_mag <= $signed({48'd0, settle_limit_q}));
    acc = $signed({1'b0, gain_p_q}) * err + $signed({1'b0, gain_i_q}) * integ
        + $signed({1'b0, gain_d_q}) * diff;
    acc_mag = acc[127] ? -acc : acc;
    whole = acc_mag >> GAIN_FRACTION_BITS_DEF;
    mag8 = (whole > 127) ? {1'b0, DRIVE_MAG_MAX} : whole[7:0];
    drive = acc[127] ? -mag8 : mag8;
  endfunction

  function automatic drive_cmd_t pid_tick(input logic [IN_W-1:0] word);
    drive_cmd_t cmd;
    pid_lane(0, word[0*POS_W +: POS_W], word[2*POS_W +: POS_W], cmd.drive_left,
             cmd.settled_left);
    pid_lane(1, word[1*POS_W +: POS_W], word[3*POS_W +: POS_W], cmd.drive_right,
             cmd.settled_right);
    return cmd;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_expect_q.push_back(pid_tick(in_tdata));
        ticks_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= tick_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_expect_q.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = drive_expect_q.pop_front();
          check_field("drive_left", want.drive_left, out_tdata[7:0]);
          check_field("drive_right", want.drive_right, out_tdata[15:8]);
          check_field("settled_left", {7'd0, want.settled_left}, {7'd0, out_tdata[16]});
          check_field("settled_right", {7'd0, want.settled_right}, {7'd0, out_tdata[17]});
        end
      end
      if (hold_seen_count != hold_req_count) begin
        hold_seen_count = hold_req_count;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [GAIN_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P:       gain_p_q = value;
      REG_GAIN_I:       gain_i_q = value;
      REG_GAIN_D:       gain_d_q = value;
      REG_SETTLE_LIMIT: settle_limit_q = value[LIMIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic write_stray_reg();
    write_reg(CFG_INDEX_BITS'($urandom_range((1 << CFG_INDEX_BITS) - 1,
                                             int'(REG_SETTLE_LIMIT) + 1)),
              GAIN_BITS'($urandom));
  endtask

  task automatic write_random_gains();
    write_reg(REG_GAIN_P, GAIN_BITS'($urandom_range(1 << (GAIN_FRACTION_BITS_DEF + 1))));
    write_reg(REG_GAIN_I, GAIN_BITS'($urandom_range(1 << (GAIN_FRACTION_BITS_DEF - 8))));
    write_reg(REG_GAIN_D, GAIN_BITS'($urandom_range(1 << GAIN_FRACTION_BITS_DEF)));
    write_reg(REG_SETTLE_LIMIT, GAIN_BITS'($urandom_range(300)));
  endtask

  task automatic drain();
    while (ticks_accepted != ticks_queued || drive_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void queue_tick(input logic [POS_W-1:0] tgt_l, input logic [POS_W-1:0] tgt_r,
                                     input logic [POS_W-1:0] pos_l, input logic [POS_W-1:0] pos_r);
    tick_queue.push_back(IN_W'({pos_r, pos_l, tgt_r, tgt_l}));
    ticks_queued++;
  endfunction

  function automatic void gen_lane(input int lane, output logic [POS_W-1:0] tgt,
                                   output logic [POS_W-1:0] pos);
    int unsigned      pick;
    logic [POS_W-1:0] off;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) walk_tgt[lane] = $urandom;
    else walk_tgt[lane] = walk_tgt[lane] + $urandom_range(100) - 50;
    tgt = walk_tgt[lane];
    if (pick < 10) begin
      pos = $urandom;
    end else if (pick < 20) begin
      pos = tgt;
    end else if (pick < 45) begin
      off = settle_limit_q + $urandom_range(2) - 1;
      pos = $urandom_range(1) ? tgt + off : tgt - off;
    end else begin
      pos = tgt + $urandom_range(400) - 200;
    end
  endfunction

  function automatic void queue_random_ticks(input int n);
    logic [POS_W-1:0] tl, tr, pl, pr;
    repeat (n) begin
      gen_lane(0, tl, pl);
      gen_lane(1, tr, pr);
      queue_tick(tl, tr, pl, pr);
    end
  endfunction

  function automatic void queue_windup(input int n, input bit up);
    logic [POS_W-1:0] hi, lo;
    repeat (n) begin
      hi = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
      lo = 32'h8000_0000 | $urandom_range(32'h3FFF_FFFF);
      if (up) queue_tick(hi, lo, lo, hi);
      else queue_tick(lo, hi, hi, lo);
    end
  endfunction

  task automatic run_random(input int n, input int unsigned idle, input int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    queue_random_ticks(n);
    drain();
  endtask

  initial begin
    int unsigned modes [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{34, 34}};
    int unsigned m;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_tick(0, 0, 0, 0);
    queue_tick(POS_MAX, POS_MIN, POS_MIN, POS_MAX);
    queue_tick(POS_MAX, POS_MIN, POS_MIN, POS_MAX);
    queue_tick(POS_MIN, POS_MAX, POS_MAX, POS_MIN);
    queue_tick(20, -20, 0, 0);
    queue_tick(21, -21, 0, 0);
    queue_tick(0, 0, 20, 21);
    queue_tick(POS_MAX, POS_MIN, POS_MAX, POS_MIN);
    queue_tick(1, -1, 0, 0);
    queue_tick(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_tick(100, 100, 90, 110);
    queue_tick(100, 100, 95, 105);
    queue_tick(100, 100, 100, 100);
    queue_tick(-1, 0, 0, -1);
    drain();

    write_reg(REG_GAIN_P, '1);
    write_reg(REG_GAIN_I, '1);
    write_reg(REG_GAIN_D, '1);
    write_reg(REG_SETTLE_LIMIT, '1);
    write_stray_reg();
    queue_tick(POS_MAX, POS_MIN, POS_MIN, POS_MAX);
    queue_tick(0, 0, 32'h0000_FFFF, 32'h0001_0000);
    run_random(150, 0, 0);

    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_SETTLE_LIMIT, '0);
    run_random(100, 85, 0);

    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, 24'd1);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_SETTLE_LIMIT, 24'd1000);
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    queue_windup(180, 1'b1);
    queue_windup(180, 1'b0);
    drain();

    write_reg(REG_GAIN_P, GAIN_P_RESET);
    write_reg(REG_GAIN_I, GAIN_I_RESET);
    write_reg(REG_GAIN_D, GAIN_D_RESET);
    write_reg(REG_SETTLE_LIMIT, GAIN_BITS'(SETTLE_LIMIT_RESET));
    write_stray_reg();
    run_random(200, 0, 85);

    write_random_gains();
    run_random(200, 34, 34);

    write_random_gains();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_count++;
    queue_random_ticks(60);
    drain();

    write_random_gains();
    repeat (25) begin
      m = $urandom_range(3);
      send_idle_pct  = modes[m][0];
      recv_stall_pct = modes[m][1];
      queue_random_ticks($urandom_range(12, 1));
      while (ticks_accepted != ticks_queued || drive_expect_q.size() != 0) @(posedge clk);
    end
    drain();

    for (int k = 0; k < 4; k++) begin
      write_random_gains();
      run_random(75, modes[k][0], modes[k][1]);
    end

    repeat (10) @(posedge clk);
    if (drive_expect_q.size() != 0) begin
      $display("%0t: expected words left over, expected 0, actual %0d", $time,
               drive_expect_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/dcpd_pkg.sv
rtl/dcpd_lane.sv
rtl/dual_channel_pid_drive.sv
dv/tb_dual_channel_pid_drive.sv
